### rtl/core/csue_pkg.sv
package csue_pkg;

    localparam int unsigned DEF_MAX_COLUMNS = 256;
    localparam int unsigned DEF_MAX_ROWS    = 256;
    localparam int unsigned DEF_TABLE_DEPTH = 512;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    typedef enum logic [1:0] {
        OP_WR_PIXEL = 2'd0,
        OP_WR_TABLE = 2'd1,
        OP_RD_PIXEL = 2'd2,
        OP_NOP      = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT      = 2'd0,
        CFG_ACTIVE_COLUMNS = 2'd1,
        CFG_SHIFT_AMOUNT   = 2'd2,
        CFG_TABLE_START    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] column;
        logic [7:0] row;
        logic [7:0] pixel_in;
        logic [8:0] table_addr;
        logic [7:0] table_byte;
    } csue_in_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       zero_filled;
    } csue_out_t;

    typedef logic [255:0][7:0] mod_tab_t;

    // v mod m for every byte value v, built by a wrapping counter
    function automatic mod_tab_t build_mod_tab(input int unsigned m);
        mod_tab_t    tab;
        int unsigned r;
        r = 0;
        for (int unsigned i = 0; i < 256; i++) begin
            tab[i] = 8'(r);
            r = (r + 1 == m) ? 0 : r + 1;
        end
        return tab;
    endfunction

endpackage

### rtl/core/column_shift_up_engine_top.sv
// channel | ports                      | accepted when
// input   | s_valid s_ready s_data     | s_valid && s_ready
// result  | m_valid m_ready m_data     | m_valid && m_ready
// config  | cfg_wr_en cfg_index cfg_wr_data | cfg_wr_en
//
// a write item completes when it is accepted; a read item passes the offset
// table read, then the pixel store read, then the result register, which waits
// until the result channel is free. one item is in flight at a time.
// aresetn clears control state, config and result registers; both memories and the datapath registers stay unknown.
// a result waiting on m_ready does not block new items until the next read
// reaches the result register.
module column_shift_up_engine_top #(
    parameter int unsigned MAX_COLUMNS = csue_pkg::DEF_MAX_COLUMNS,
    parameter int unsigned MAX_ROWS    = csue_pkg::DEF_MAX_ROWS,
    parameter int unsigned TABLE_DEPTH = csue_pkg::DEF_TABLE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  csue_pkg::csue_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output csue_pkg::csue_out_t               m_data,
    input  logic                              cfg_wr_en,
    input  logic [csue_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [csue_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import csue_pkg::*;

    localparam int unsigned PIX_DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int unsigned PIX_AW    = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
    localparam int unsigned TAB_AW    = $clog2(TABLE_DEPTH);
    localparam mod_tab_t    ROW_MOD   = build_mod_tab(MAX_ROWS);
    localparam mod_tab_t    COL_MOD   = build_mod_tab(MAX_COLUMNS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TAB,
        ST_PIX
    } state_t;

    state_t          state_reg;
    logic            m_valid_reg;
    csue_out_t       m_data_reg;

    logic [7:0]      row_count_reg;
    logic [7:0]      active_columns_reg;
    logic [4:0]      shift_amount_reg;
    logic [7:0]      table_start_reg;

    logic [7:0]      col_reg;
    logic [7:0]      row_reg;
    logic            zero_reg;

    logic [7:0]      pix_mem [PIX_DEPTH];
    logic [7:0]      tab_mem [TABLE_DEPTH];
    logic [7:0]      pix_rdata_reg;
    logic [7:0]      tab_rdata_reg;

    logic            in_accept;
    op_t             in_op;
    logic            pix_wr_en;
    logic            tab_wr_en;
    logic            tab_rd_en;
    logic            pix_rd_en;
    logic [PIX_AW-1:0] pix_wr_addr;
    logic [PIX_AW-1:0] pix_rd_addr;
    logic [TAB_AW-1:0] tab_wr_addr;
    logic [TAB_AW-1:0] tab_rd_addr;
    logic [9:0]      tab_wr_sum;
    logic [9:0]      tab_rd_sum;
    logic [7:0]      shift_n;
    logic [8:0]      row_plus_n;
    logic            inactive;
    logic            zero_next;
    logic [7:0]      src_row;
    logic            out_free;

    function automatic logic [PIX_AW-1:0] pix_addr(input logic [7:0] r, input logic [7:0] c);
        logic [PIX_AW:0] a;
        a = (PIX_AW+1)'(ROW_MOD[r]) * (PIX_AW+1)'(MAX_COLUMNS) + (PIX_AW+1)'(COL_MOD[c]);
        return a[PIX_AW-1:0];
    endfunction

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;
    assign in_op     = op_t'(s_data.op);
    assign pix_wr_en = in_accept && (in_op == OP_WR_PIXEL);
    assign tab_wr_en = in_accept && (in_op == OP_WR_TABLE);
    assign tab_rd_en = in_accept && (in_op == OP_RD_PIXEL);
    assign pix_rd_en = (state_reg == ST_TAB);
    assign out_free  = !m_valid_reg || m_ready;

    assign pix_wr_addr = pix_addr(s_data.row, s_data.column);

    assign tab_wr_sum  = (10'(s_data.table_addr) >= 10'(TABLE_DEPTH))
                       ? 10'(s_data.table_addr) - 10'(TABLE_DEPTH)
                       : 10'(s_data.table_addr);
    assign tab_wr_addr = tab_wr_sum[TAB_AW-1:0];

    always_comb begin
        tab_rd_sum = 10'(table_start_reg) + 10'(s_data.column);
        if (tab_rd_sum >= 10'(TABLE_DEPTH)) begin
            tab_rd_sum = tab_rd_sum - 10'(TABLE_DEPTH);
        end
    end
    assign tab_rd_addr = tab_rd_sum[TAB_AW-1:0];

    assign shift_n    = (shift_amount_reg[4:3] != 2'd0) ? 8'd0
                      : (tab_rdata_reg >> shift_amount_reg[2:0]);
    assign row_plus_n = 9'(row_reg) + 9'(shift_n);
    assign inactive   = (col_reg >= active_columns_reg) || (row_reg >= row_count_reg);
    assign zero_next  = !inactive && (row_plus_n >= 9'(row_count_reg));
    assign src_row    = inactive ? row_reg : row_plus_n[7:0];
    assign pix_rd_addr = pix_addr(src_row, col_reg);

    always_ff @(posedge aclk) begin
        if (pix_wr_en) begin
            pix_mem[pix_wr_addr] <= s_data.pixel_in;
        end
        if (pix_rd_en) begin
            pix_rdata_reg <= pix_mem[pix_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (tab_wr_en) begin
            tab_mem[tab_wr_addr] <= s_data.table_byte;
        end
        if (tab_rd_en) begin
            tab_rdata_reg <= tab_mem[tab_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg      <= '0;
            active_columns_reg <= '0;
            shift_amount_reg   <= '0;
            table_start_reg    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROW_COUNT:      row_count_reg      <= cfg_wr_data;
                CFG_ACTIVE_COLUMNS: active_columns_reg <= cfg_wr_data;
                CFG_SHIFT_AMOUNT:   shift_amount_reg   <= cfg_wr_data[4:0];
                CFG_TABLE_START:    table_start_reg    <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (tab_rd_en) begin
            col_reg <= s_data.column;
            row_reg <= s_data.row;
        end
        if (state_reg == ST_TAB) begin
            zero_reg <= zero_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_PIX)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (tab_rd_en) begin
                        state_reg <= ST_TAB;
                    end
                end
                ST_TAB: begin
                    state_reg <= ST_PIX;
                end
                ST_PIX: begin
                    if (out_free) begin
                        m_valid_reg            <= 1'b1;
                        m_data_reg.pixel_out   <= zero_reg ? 8'd0 : pix_rdata_reg;
                        m_data_reg.zero_filled <= zero_reg;
                        state_reg              <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### verif/tb.sv
module tb;
    import csue_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 8;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    csue_in_t              s_data      = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    csue_out_t             m_data;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    column_shift_up_engine_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 aclk = ~aclk;

    // shadow of the block contents, updated as items are accepted
    logic [7:0] frame_mem  [0:65535];
    logic [7:0] offset_mem [0:511];
    int rows_cfg  = 0;
    int cols_cfg  = 0;
    int shamt_cfg = 0;
    int start_cfg = 0;

    // what the generator already knows will be written
    logic [7:0] plan_offset    [0:511];
    bit         plan_offset_ok [0:511];
    bit         plan_pixel_ok  [0:65535];

    csue_in_t  pending_items [$];
    csue_out_t expected_pix  [$];

    int issued_count   = 0;
    int accepted_count = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;
    int in_idle_pct    = 9;
    int out_idle_pct   = 9;
    bit in_taken       = 1'b0;

    function automatic int column_shift(input logic [7:0] raw);
        return (shamt_cfg >= 8) ? 0 : int'(raw >> shamt_cfg);
    endfunction

    function automatic bit predict_item(input csue_in_t it, output csue_out_t res);
        int n;
        int tab_idx;
        res = '0;
        case (it.op)
            OP_WR_PIXEL: begin
                frame_mem[{it.row, it.column}] = it.pixel_in;
                return 1'b0;
            end
            OP_WR_TABLE: begin
                offset_mem[it.table_addr] = it.table_byte;
                return 1'b0;
            end
            OP_RD_PIXEL: begin
                if (int'(it.column) >= cols_cfg || int'(it.row) >= rows_cfg) begin
                    res.pixel_out = frame_mem[{it.row, it.column}];
                end else begin
                    tab_idx = (start_cfg + int'(it.column)) % 512;
                    n = column_shift(offset_mem[tab_idx]);
                    if (n > rows_cfg || int'(it.row) >= rows_cfg - n) begin
                        res.zero_filled = 1'b1;
                    end else begin
                        res.pixel_out = frame_mem[{8'(int'(it.row) + n), it.column}];
                    end
                end
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    function automatic csue_in_t random_item(input op_t op);
        csue_in_t it;
        it.op         = op;
        it.column     = 8'($urandom);
        it.row        = 8'($urandom);
        it.pixel_in   = 8'($urandom);
        it.table_addr = 9'($urandom);
        it.table_byte = 8'($urandom);
        return it;
    endfunction

    task automatic queue_item(input csue_in_t it);
        pending_items.push_back(it);
        issued_count++;
        if (it.op == OP_WR_PIXEL) begin
            plan_pixel_ok[{it.row, it.column}] = 1'b1;
        end
        if (it.op == OP_WR_TABLE) begin
            plan_offset[it.table_addr]    = it.table_byte;
            plan_offset_ok[it.table_addr] = 1'b1;
        end
    endtask

    task automatic queue_pixel(input int row, input int col, input int value);
        csue_in_t it;
        it          = random_item(OP_WR_PIXEL);
        it.row      = 8'(row);
        it.column   = 8'(col);
        it.pixel_in = 8'(value);
        queue_item(it);
    endtask

    task automatic queue_offset(input int addr, input int value);
        csue_in_t it;
        it            = random_item(OP_WR_TABLE);
        it.table_addr = 9'(addr);
        it.table_byte = 8'(value);
        queue_item(it);
    endtask

    // entries a read may touch are written first
    task automatic queue_read(input int row, input int col);
        csue_in_t it;
        int tab_idx;
        int low_row;
        tab_idx = (start_cfg + col) % 512;
        if (!plan_offset_ok[tab_idx]) begin
            queue_offset(tab_idx, $urandom_range(255));
        end
        if (!plan_pixel_ok[{8'(row), 8'(col)}]) begin
            queue_pixel(row, col, $urandom_range(255));
        end
        low_row = (row + column_shift(plan_offset[tab_idx])) % 256;
        if (!plan_pixel_ok[{8'(low_row), 8'(col)}]) begin
            queue_pixel(low_row, col, $urandom_range(255));
        end
        it        = random_item(OP_RD_PIXEL);
        it.row    = 8'(row);
        it.column = 8'(col);
        queue_item(it);
    endtask

    task automatic queue_random(input int count);
        int pick;
        int row;
        int col;
        repeat (count) begin
            pick = $urandom_range(99);
            col = (cols_cfg > 0 && $urandom_range(3) != 0) ?
                  $urandom_range(cols_cfg - 1) : $urandom_range(255);
            row = (rows_cfg > 0 && $urandom_range(3) != 0) ?
                  $urandom_range(rows_cfg - 1) : $urandom_range(255);
            if (pick < 55) begin
                queue_read(row, col);
            end else if (pick < 75) begin
                queue_pixel(row, col, $urandom_range(255));
            end else if (pick < 88) begin
                queue_offset($urandom_range(1) ? (start_cfg + col) % 512 : $urandom_range(511),
                             $urandom_range(255));
            end else if (pick < 93) begin
                queue_item(random_item(OP_NOP));
            end else begin
                queue_read($urandom_range(255), $urandom_range(255));
            end
        end
    endtask

    task automatic wait_idle;
        while (accepted_count != issued_count || expected_pix.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= 8'(value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic set_config(input int rows, input int cols, input int shamt, input int start);
        wait_idle();
        write_reg(CFG_ROW_COUNT, rows);
        write_reg(CFG_ACTIVE_COLUMNS, cols);
        write_reg(CFG_SHIFT_AMOUNT, shamt);
        write_reg(CFG_TABLE_START, start);
        rows_cfg  = rows;
        cols_cfg  = cols;
        shamt_cfg = shamt;
        start_cfg = start;
    endtask

    // driver
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_taken)) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                s_data  <= pending_items.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // monitor and checker
    always @(posedge aclk) begin
        csue_out_t want;
        csue_out_t res;
        bit        out_taken;
        in_taken  = aresetn && s_valid && s_ready;
        out_taken = aresetn && m_valid && m_ready;
        if (out_taken) begin
            if (expected_pix.size() == 0) begin
                $error("unexpected result: pixel_out %0h zero_filled %0b",
                       m_data.pixel_out, m_data.zero_filled);
                error_count++;
            end else begin
                want = expected_pix.pop_front();
                if (m_data.pixel_out !== want.pixel_out) begin
                    $error("pixel_out: expected %0h, got %0h", want.pixel_out, m_data.pixel_out);
                    error_count++;
                end
                if (m_data.zero_filled !== want.zero_filled) begin
                    $error("zero_filled: expected %0b, got %0b",
                           want.zero_filled, m_data.zero_filled);
                    error_count++;
                end
            end
        end
        if (in_taken) begin
            accepted_count++;
            if (predict_item(s_data, res)) begin
                expected_pix.push_back(res);
            end
        end
        if (in_taken || out_taken) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int rows;
        int cols;
        int shamt;
        int start;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // registers at reset values: every place is inactive
        queue_item('1);
        queue_item('0);
        queue_read(0, 0);
        queue_offset(511, 255);
        queue_read(255, 255);

        // widest setting
        set_config(255, 255, 0, 255);
        queue_offset(255, 0);
        queue_pixel(254, 0, 8'ha5);
        queue_read(0, 0);
        queue_read(254, 0);
        queue_read(255, 0);
        queue_offset(258, 255);
        queue_read(0, 3);
        queue_offset(259, 1);
        queue_read(253, 4);
        queue_read(254, 4);
        queue_read(10, 255);
        queue_read(0, 254);

        // large shift amounts give no shift
        set_config(16, 8, 31, 0);
        queue_read(3, 1);
        queue_read(15, 7);
        set_config(16, 8, 8, 0);
        queue_read(2, 2);

        // one row: shift equal to and beyond the height
        set_config(1, 1, 6, 100);
        queue_offset(100, 64);
        queue_read(0, 0);
        queue_offset(100, 255);
        queue_read(0, 0);
        queue_read(1, 0);

        for (int p = 0; p < 10; p++) begin
            case ($urandom_range(3))
                0: rows = $urandom_range(32, 1);
                1: rows = 255;
                2: rows = $urandom_range(255);
                default: rows = $urandom_range(8, 1);
            endcase
            case ($urandom_range(3))
                0: cols = $urandom_range(16, 1);
                1: cols = ($urandom_range(1) != 0) ? 255 : 0;
                default: cols = $urandom_range(255);
            endcase
            shamt = ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(9);
            start = $urandom_range(255);
            set_config(rows, cols, shamt, start);
            in_idle_pct  = (p == 3) ? 0 : 9;
            out_idle_pct = (p == 3) ? 0 : 9;
            queue_random(60);
        end

        wait_idle();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
